>>> hw/rtl/catmull_rom_trail_points_top_assert.svh
// Assertion macros for the trail point generator; clk and rst come from the using scope.
`ifndef CATMULL_ROM_TRAIL_POINTS_TOP_ASSERT_SVH
`define CATMULL_ROM_TRAIL_POINTS_TOP_ASSERT_SVH

// same-cycle implication
`define CRTP_ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("crtp assertion failed");

// next-cycle implication
`define CRTP_ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("crtp assertion failed");

`endif

>>> hw/rtl/crtp_pkg.sv
// Shared types and constants of the trail point generator.
package crtp_pkg;
  localparam int HISTORY_DEPTH_DEF = 64;
  localparam int MAX_POINTS_DEF    = 64;
  localparam int COORD_W   = 32;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int IDX_W     = 6;
  localparam int FRAC_BITS = 16;
  localparam int FRAC_W    = 17;
  localparam int ACC_W     = 38;

  localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS     = 2'd1;
  localparam logic [CFG_W-1:0] HIST_LEN_RST = 7'd16;
  localparam logic [CFG_W-1:0] NUM_PTS_RST  = 7'd32;
  localparam logic [FRAC_W-1:0] FRAC_ONE    = 17'h10000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef enum logic [3:0] {
    S_IDLE, S_P0, S_DIV, S_STEP, S_SEG, S_READ, S_EVST, S_EVAL, S_EMIT
  } top_state_t;

  typedef enum logic [1:0] {
    SP_IDLE, SP_COEF, SP_MUL, SP_ADD
  } sp_state_t;
endpackage

>>> hw/rtl/crtp_if.sv
// Valid/ready channels for pivot words and trail point words.
interface crtp_pivot_if;
  logic valid;
  logic ready;
  crtp_pkg::coord_t pivot_x;
  crtp_pkg::coord_t pivot_y;
  crtp_pkg::coord_t pivot_z;
  modport source (output valid, pivot_x, pivot_y, pivot_z, input ready);
  modport sink (input valid, pivot_x, pivot_y, pivot_z, output ready);
endinterface

interface crtp_point_if;
  logic valid;
  logic ready;
  logic [crtp_pkg::IDX_W-1:0] point_index;
  crtp_pkg::coord_t point_x;
  crtp_pkg::coord_t point_y;
  crtp_pkg::coord_t point_z;
  logic last;
  modport source (output valid, point_index, point_x, point_y, point_z, last, input ready);
  modport sink (input valid, point_index, point_x, point_y, point_z, last, output ready);
endinterface

>>> hw/rtl/crtp_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module crtp_div #(
  parameter int NW = 23,
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem,
  output logic          done
);
  localparam int CNT_W = $clog2(NW + 1);

  logic          busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0] dsr;
  logic [DW:0]   sh;
  logic          ge;

  assign sh = {rem, quo[NW-1]};
  assign ge = sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out of quo while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[NW-2:0], ge};
      rem <= ge ? DW'(sh - {1'b0, dsr}) : DW'(sh);
    end
  end
endmodule

>>> hw/rtl/crtp_spline.sv
// Catmull-Rom evaluator: coefficients and Horner steps, one coordinate at a time.
module crtp_spline (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  crtp_pkg::vec_t             v [4],
  input  logic [crtp_pkg::FRAC_W-1:0] frac,
  output crtp_pkg::vec_t             res,
  output logic                       done
);
  import crtp_pkg::*;

  sp_state_t state, state_next;
  logic [1:0] c, k;
  logic signed [ACC_W-1:0] acc, acc_sum;
  logic signed [ACC_W-1:0] a [3];
  logic signed [ACC_W+FRAC_W:0] prod;
  logic signed [ACC_W-1:0] e [4];
  logic last_add;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      case (c)
        2'd0:    e[j] = ACC_W'(v[j].x);
        2'd1:    e[j] = ACC_W'(v[j].y);
        default: e[j] = ACC_W'(v[j].z);
      endcase
    end
  end

  assign acc_sum  = ACC_W'(prod >>> FRAC_BITS) + a[2'd2 - k];
  assign last_add = (state == SP_ADD) && (k == 2'd2);

  always_comb begin
    state_next = state;
    case (state)
      SP_IDLE: if (start) state_next = SP_COEF;
      SP_COEF: state_next = SP_MUL;
      SP_MUL:  state_next = SP_ADD;
      SP_ADD:  begin
        if (!last_add) state_next = SP_MUL;
        else if (c == 2'd2) state_next = SP_IDLE;
        else state_next = SP_COEF;
      end
      default: state_next = SP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SP_IDLE;
      done  <= 1'b0;
      c     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      done  <= last_add && (c == 2'd2);
      if (state == SP_IDLE) c <= '0;
      else if (last_add) c <= c + 1'b1;
      if (state == SP_COEF) k <= '0;
      else if (state == SP_ADD) k <= k + 1'b1;
    end
  end

  // a3 goes straight into the accumulator
  always_ff @(posedge clk) begin
    case (state)
      SP_COEF: begin
        a[0] <= e[1] <<< 1;
        a[1] <= e[2] - e[0];
        a[2] <= (e[0] <<< 1) - (e[1] <<< 2) - e[1] + (e[2] <<< 2) - e[3];
        acc  <= e[1] + (e[1] <<< 1) - e[0] - e[2] - (e[2] <<< 1) + e[3];
      end
      SP_MUL: prod <= acc * $signed({1'b0, frac});
      SP_ADD: begin
        acc <= acc_sum;
        if (last_add) begin
          case (c)
            2'd0:    res.x <= COORD_W'(acc_sum >>> 1);
            2'd1:    res.y <= COORD_W'(acc_sum >>> 1);
            default: res.z <= COORD_W'(acc_sum >>> 1);
          endcase
        end
      end
      default: ;
    endcase
  end
endmodule

>>> hw/rtl/catmull_rom_trail_points_top.sv
// Top level of the Catmull-Rom trail point generator.
// Usage:
//  - pivot channel: one word per frame, the pivot x/y/z in Q16.16.
//  - trail channel: num_points words per frame (saturated to MAX_POINTS),
//    point_index 0..n-1, last set on the final word. No words while the
//    history holds four points or fewer, or when num_points is zero.
//  - cfg port: write history_length (index 0) or num_points (index 1)
//    while the block is idle; other indexes are ignored.
// Timing: the pivot is written to the history memory on accept. Point 0
// is loaded from the S_P0 state once the output register is free. After
// that come one divider pass per frame, then per point a quotient step,
// four single-port memory reads and a Horner pass per coordinate on the
// one 38x18 multiplier.
// Reset: count and newest slot clear, registers return to 16 and 32; the
// history memory is not cleared, only written entries are read.
// Stall: the trail output register holds its word until taken; the
// sequencer waits for it, and a new pivot is taken once the last word of
// a frame sits in that register.
module catmull_rom_trail_points_top #(
  parameter int HISTORY_DEPTH = crtp_pkg::HISTORY_DEPTH_DEF,
  parameter int MAX_POINTS    = crtp_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [crtp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [crtp_pkg::CFG_W-1:0]    cfg_data,
  crtp_pivot_if.sink                    pivot,
  crtp_point_if.source                  trail
);
  import crtp_pkg::*;

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int PW = $clog2(MAX_POINTS + 1);
  localparam int KW = CW + FRAC_BITS;
  localparam int EW = ((CW > CFG_W) ? CW : CFG_W) + 1;

  // configuration
  logic [CFG_W-1:0] hist_len, num_pts;
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_len <= HIST_LEN_RST;
      num_pts  <= NUM_PTS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HISTORY_LENGTH: hist_len <= cfg_data;
        CFG_NUM_POINTS:     num_pts  <= cfg_data;
        default: ;
      endcase
    end
  end

  // points per frame, saturated
  logic [PW-1:0] n, den;
  assign n   = (num_pts > CFG_W'(MAX_POINTS)) ? PW'(MAX_POINTS) : PW'(num_pts);
  assign den = n - 1'b1;

  top_state_t state, state_next;
  logic [AW-1:0] newest, newest_next;
  logic [CW-1:0] count, count_next, cnt_m4;
  logic [EW-1:0] newc;
  vec_t          piv;
  logic          accept, out_free;

  // control outputs
  logic mem_re, div_start, sp_start, out_load;

  assign accept   = pivot.valid && pivot.ready;
  assign out_free = !trail.valid || trail.ready;
  assign cnt_m4   = count - CW'(4);

  assign newest_next = (newest == '0) ? AW'(HISTORY_DEPTH - 1) : newest - 1'b1;

  always_comb begin
    newc = EW'(count) + 1'b1;
    if (newc > EW'(hist_len)) newc = EW'(count);
    if (newc > EW'(HISTORY_DEPTH)) newc = EW'(HISTORY_DEPTH);
    count_next = CW'(newc);
  end

  // divider: ((count-3) << 16) / (n-1), once per frame
  logic [KW-1:0] q0;
  logic [PW-1:0] r0;
  logic          div_done;
  crtp_div #(.NW(KW), .DW(PW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({count - CW'(3), {FRAC_BITS{1'b0}}}),
    .divisor  (den),
    .quo      (q0),
    .rem      (r0),
    .done     (div_done)
  );

  // running quotient Q = floor(i*(count-3)*65536/(n-1)) and its remainder
  logic [KW-1:0] qq;
  logic [PW:0]   rr, rsum;
  logic [PW-1:0] pi;
  logic [CW-1:0] seg, seg_raw;
  logic [FRAC_W-1:0] frac;
  assign rsum    = rr + {1'b0, r0};
  assign seg_raw = qq[KW-1:FRAC_BITS];

  // history memory
  logic [3*COORD_W-1:0] mem [HISTORY_DEPTH];
  logic [3*COORD_W-1:0] rdata;
  logic [2:0]    rd_cnt;
  logic [AW:0]   raddr_sum;
  logic [AW-1:0] raddr;
  vec_t          v [4];

  assign raddr_sum = {1'b0, newest} + {1'b0, AW'(seg)} + (AW + 1)'(rd_cnt);
  assign raddr = (raddr_sum >= (AW + 1)'(HISTORY_DEPTH)) ?
                 AW'(raddr_sum - (AW + 1)'(HISTORY_DEPTH)) : AW'(raddr_sum);

  always_ff @(posedge clk) begin
    if (accept) mem[newest_next] <= {pivot.pivot_x, pivot.pivot_y, pivot.pivot_z};
    if (mem_re) rdata <= mem[raddr];
  end

  // spline unit
  vec_t sp_res;
  logic sp_done;
  crtp_spline u_spline (
    .clk   (clk),
    .rst   (rst),
    .start (sp_start),
    .v     (v),
    .frac  (frac),
    .res   (sp_res),
    .done  (sp_done)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) begin
        if (count_next <= CW'(4) || n == '0) state_next = S_IDLE;
        else state_next = S_P0;
      end
      S_P0:   if (out_free) state_next = (n == PW'(1)) ? S_IDLE : S_DIV;
      S_DIV:  if (div_done) state_next = S_STEP;
      S_STEP: state_next = S_SEG;
      S_SEG:  state_next = S_READ;
      S_READ: if (rd_cnt == 3'd4) state_next = S_EVST;
      S_EVST: state_next = S_EVAL;
      S_EVAL: if (sp_done) state_next = S_EMIT;
      S_EMIT: if (out_free) state_next = (pi == den) ? S_IDLE : S_STEP;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pivot.ready = (state == S_IDLE);
    mem_re      = (state == S_READ) && (rd_cnt < 3'd4);
    div_start   = (state == S_P0) && out_free && (n != PW'(1));
    sp_start    = (state == S_EVST);
    out_load    = ((state == S_P0) || (state == S_EMIT)) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      newest <= '0;
      count  <= '0;
      trail.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        newest <= newest_next;
        count  <= count_next;
      end
      if (out_load) trail.valid <= 1'b1;
      else if (trail.ready) trail.valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) piv <= '{pivot.pivot_x, pivot.pivot_y, pivot.pivot_z};
    case (state)
      S_P0: begin
        qq <= '0;
        rr <= '0;
        pi <= PW'(1);
      end
      S_STEP: begin
        if (rsum >= {1'b0, den}) begin
          rr <= rsum - {1'b0, den};
          qq <= qq + q0 + 1'b1;
        end else begin
          rr <= rsum;
          qq <= qq + q0;
        end
      end
      S_SEG: begin
        rd_cnt <= '0;
        // past the last segment the fraction reaches exactly one
        if (seg_raw > cnt_m4) begin
          seg  <= cnt_m4;
          frac <= {1'b0, qq[FRAC_BITS-1:0]} + FRAC_ONE;
        end else begin
          seg  <= seg_raw;
          frac <= {1'b0, qq[FRAC_BITS-1:0]};
        end
      end
      S_READ: begin
        rd_cnt <= rd_cnt + 1'b1;
        if (rd_cnt != 3'd0) v[2'(rd_cnt - 3'd1)] <= rdata;
      end
      S_EMIT: if (out_free) pi <= pi + 1'b1;
      default: ;
    endcase
  end

  // output word
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_P0) begin
        trail.point_index <= '0;
        trail.point_x     <= piv.x;
        trail.point_y     <= piv.y;
        trail.point_z     <= piv.z;
        trail.last        <= (n == PW'(1));
      end else begin
        trail.point_index <= IDX_W'(pi);
        trail.point_x     <= sp_res.x;
        trail.point_y     <= sp_res.y;
        trail.point_z     <= sp_res.z;
        trail.last        <= (pi == den);
      end
    end
  end

  `include "catmull_rom_trail_points_top_assert.svh"

  `CRTP_ASSERT_IMP(a_seg_clamped, state == S_READ, seg <= cnt_m4)
  `CRTP_ASSERT_IMP(a_frac_range, state == S_READ, frac <= FRAC_ONE)
  `CRTP_ASSERT_IMP(a_rem_below_den, state == S_SEG, rr < {1'b0, den})
  `CRTP_ASSERT_IMP(a_last_index, trail.valid && trail.last,
                   trail.point_index == IDX_W'(den))
  `CRTP_ASSERT_NXT(a_short_history, accept && count_next <= CW'(4), state == S_IDLE)
endmodule

>>> dv/testbench.sv
// Self-checking testbench for the Catmull-Rom trail point generator.
module testbench;
  import crtp_pkg::*;

  localparam int DEPTH      = HISTORY_DEPTH_DEF;
  localparam int MAXPTS     = MAX_POINTS_DEF;
  localparam int CYCLE_CAP  = 3000000;
  localparam int DRAIN_WAIT = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct {
    logic [IDX_W-1:0] index;
    coord_t x;
    coord_t y;
    coord_t z;
    logic last;
  } trail_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  crtp_pivot_if pivot ();
  crtp_point_if trail ();

  catmull_rom_trail_points_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pivot(pivot.sink), .trail(trail.source)
  );

  always #4 clk = ~clk;

  // Shadow of the block: history ring, count, newest slot, registers.
  vec_t hist_ring [DEPTH];
  int unsigned hist_cnt;
  int unsigned hist_head;
  int unsigned len_reg;
  int unsigned pts_reg;

  trail_word_t pending_points[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  // Idle percentages for each side; zero gives back-to-back words.
  int unsigned tx_idle_pct = 50;
  int unsigned rx_idle_pct = 50;

  // Uniform Catmull-Rom in Horner form; frac in units of 2^-16.
  function automatic coord_t spline_eval(longint v0, longint v1, longint v2,
                                         longint v3, longint frac);
    longint a0, a1, a2, a3, acc;
    a0 = 2 * v1;
    a1 = v2 - v0;
    a2 = 2 * v0 - 5 * v1 + 4 * v2 - v3;
    a3 = -v0 + 3 * v1 - 3 * v2 + v3;
    acc = a3;
    acc = ((acc * frac) >>> 16) + a2;
    acc = ((acc * frac) >>> 16) + a1;
    acc = ((acc * frac) >>> 16) + a0;
    acc = acc >>> 1;
    return coord_t'(acc[31:0]);
  endfunction

  function automatic longint ring_coord(int unsigned k, int unsigned c);
    vec_t v;
    v = hist_ring[(hist_head + k) % DEPTH];
    case (c)
      0: return longint'(v.x);
      1: return longint'(v.y);
      default: return longint'(v.z);
    endcase
  endfunction

  // Push one pivot and queue the trail words it produces.
  task automatic predict_trail(vec_t p);
    int unsigned newc, n, den, numer, seg, rem;
    longint frac;
    coord_t r [3];
    trail_word_t w;
    hist_head = (hist_head + DEPTH - 1) % DEPTH;
    hist_ring[hist_head] = p;
    newc = hist_cnt + 1;
    if (newc > len_reg) newc = hist_cnt;
    if (newc > DEPTH) newc = DEPTH;
    hist_cnt = newc;
    if (hist_cnt <= 4) return;
    n = (pts_reg > MAXPTS) ? MAXPTS : pts_reg;
    for (int unsigned i = 0; i < n; i++) begin
      w.index = i[IDX_W-1:0];
      w.last = (i == n - 1);
      if (i == 0) begin
        w.x = p.x; w.y = p.y; w.z = p.z;
      end else begin
        den = n - 1;
        numer = i * (hist_cnt - 3);
        seg = numer / den;
        if (seg > hist_cnt - 4) seg = hist_cnt - 4;
        rem = numer - seg * den;
        frac = (longint'(rem) << 16) / den;
        for (int unsigned c = 0; c < 3; c++)
          r[c] = spline_eval(ring_coord(seg, c), ring_coord(seg + 1, c),
                             ring_coord(seg + 2, c), ring_coord(seg + 3, c), frac);
        w.x = r[0]; w.y = r[1]; w.z = r[2];
      end
      pending_points.push_back(w);
    end
  endtask

  function automatic int unsigned draw_idle(int unsigned pct);
    if ($urandom_range(99) < pct) return $urandom_range(9);
    return 0;
  endfunction

  // Register write; only ever called with the block idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val[CFG_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == CFG_HISTORY_LENGTH) len_reg = val & 7'h7f;
    else if (idx == CFG_NUM_POINTS) pts_reg = val & 7'h7f;
  endtask

  // Send one pivot word; valid stays high into the next word when no gap.
  task automatic send_pivot(coord_t x, coord_t y, coord_t z);
    int unsigned gap;
    vec_t p;
    gap = draw_idle(tx_idle_pct);
    @(negedge clk);
    if (gap > 0) begin
      pivot.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pivot.valid = 1'b1;
    pivot.pivot_x = x;
    pivot.pivot_y = y;
    pivot.pivot_z = z;
    p = '{x: x, y: y, z: z};
    do @(posedge clk); while (!pivot.ready);
    predict_trail(p);
  endtask

  // Wait until all trail words are out, then let the block settle.
  task automatic drain();
    @(negedge clk);
    pivot.valid = 1'b0;
    while (pending_points.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0: return coord_t'($urandom_range(8) << 16) - coord_t'(32'h40000);
      1: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      2: return coord_t'($urandom_range(32'h00ffffff)) - coord_t'(32'h00800000);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Output side: random stall ahead of each word.
  initial begin
    int unsigned w;
    trail.ready = 1'b0;
    forever begin
      w = draw_idle(rx_idle_pct);
      @(negedge clk);
      if (w > 0) begin
        trail.ready = 1'b0;
        repeat (w) @(negedge clk);
      end
      trail.ready = 1'b1;
      do @(posedge clk); while (!(trail.valid && !rst));
    end
  end

  // Checker: every accepted word against the oldest expectation.
  always @(posedge clk) begin
    trail_word_t e;
    if (!rst && trail.valid && trail.ready) begin
      if (pending_points.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("ERROR: unexpected trail word idx=%0d x=%h", trail.point_index,
                   trail.point_x);
      end else begin
        e = pending_points.pop_front();
        if (trail.point_index !== e.index || trail.point_x !== e.x ||
            trail.point_y !== e.y || trail.point_z !== e.z || trail.last !== e.last) begin
          err_count++;
          if (err_count <= 10)
            $display("ERROR: exp idx=%0d x=%h y=%h z=%h last=%b, got idx=%0d x=%h y=%h z=%h last=%b",
                     e.index, e.x, e.y, e.z, e.last, trail.point_index, trail.point_x,
                     trail.point_y, trail.point_z, trail.last);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // History of four or fewer points gives no words, then the fifth and sixth pivots give frames; extremes on all axes.
  task automatic test_short_history();
    send_pivot(32'h80000000, 32'h7fffffff, 32'h00000000);
    send_pivot(32'h7fffffff, 32'h80000000, 32'hffffffff);
    send_pivot(32'h00000000, 32'hffffffff, 32'h80000000);
    send_pivot(32'hffffffff, 32'h00000000, 32'h7fffffff);
    send_pivot(32'h80000000, 32'h80000000, 32'h80000000);
    send_pivot(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    drain();
  endtask

  // Zero, one, two and saturated point counts; spare indexes ignored.
  task automatic test_point_counts();
    write_reg(CFG_NUM_POINTS, 0);
    send_pivot(32'h00010000, 32'h00020000, 32'h00030000);
    drain();
    write_reg(CFG_NUM_POINTS, 1);
    send_pivot(32'hfff00000, 32'h00100000, 32'h12345678);
    drain();
    write_reg(CFG_NUM_POINTS, 127);
    send_pivot(32'h00000000, 32'h00000000, 32'h00000000);
    drain();
    write_reg(CFG_NUM_POINTS, 2);
    write_reg(CFG_SPARE_A, 7'h7f);
    write_reg(CFG_SPARE_B, 7'h00);
    send_pivot(32'h7fffffff, 32'h80000000, 32'h00000001);
    drain();
  endtask

  // Lowering the length below the count keeps the count where it is.
  task automatic test_shrunk_length();
    write_reg(CFG_NUM_POINTS, 7);
    write_reg(CFG_HISTORY_LENGTH, 5);
    repeat (4) send_pivot(rand_coord(), rand_coord(), rand_coord());
    drain();
  endtask

  // Random phases; one with length above the ring depth so the count saturates.
  task automatic test_random();
    int unsigned items;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 2) write_reg(CFG_HISTORY_LENGTH, 127);
      else if (ph == 5) write_reg(CFG_HISTORY_LENGTH, 64);
      else write_reg(CFG_HISTORY_LENGTH, $urandom_range(64, 5));
      if (ph == 7) write_reg(CFG_NUM_POINTS, 64);
      else write_reg(CFG_NUM_POINTS, $urandom_range(12, 2));
      tx_idle_pct = (ph % 3 == 0) ? 0 : 60;
      rx_idle_pct = (ph % 4 == 1) ? 0 : 50;
      items = (ph == 2) ? 75 : (ph == 7) ? 10 : 28;
      repeat (items) send_pivot(rand_coord(), rand_coord(), rand_coord());
      drain();
    end
  endtask

  initial begin
    pivot.valid = 1'b0;
    pivot.pivot_x = '0;
    pivot.pivot_y = '0;
    pivot.pivot_z = '0;
    hist_cnt = 0;
    hist_head = 0;
    len_reg = HIST_LEN_RST;
    pts_reg = NUM_PTS_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_short_history();
    test_point_counts();
    test_shrunk_length();
    test_random();
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
